/* rtl/bisulfite_alignment_scorer_core_defines.svh */
// ---------------------------------------------------------------------------
// Bisulfite alignment scorer - assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BISULFITE_ALIGNMENT_SCORER_CORE_DEFINES_SVH
`define BISULFITE_ALIGNMENT_SCORER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BAS_ASSERT(lbl, prop, msg) \
    `BAS_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define BAS_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define BAS_ASSERT(lbl, prop, msg)
`endif

`endif

/* rtl/bas_pkg.sv */
// ---------------------------------------------------------------------------
// Bisulfite alignment scorer - package
// Field widths, codes and the matched-base scoring rules.
// ---------------------------------------------------------------------------
package bas_pkg;

    localparam int NUM_GENOMES_DEF = 7;
    localparam int CT_GENOMES_DEF  = 4;
    localparam int TOTAL_WIDTH_DEF = 32;

    localparam int MODE_W     = 2;
    localparam int GENOME_W   = 3;
    localparam int BASE_W     = 3;
    localparam int LEN_W      = 12;
    localparam int COST_REG_W = 16;
    localparam int PEN_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    // widest per-item increment: high_cost * run_length
    localparam int INC_W      = COST_REG_W + LEN_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_MATCH    = 2'd0,
        MODE_DEL      = 2'd1,
        MODE_INS      = 2'd2,
        MODE_UNMAPPED = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH   = 2'd0,
        CFG_MEDIUM = 2'd1,
        CFG_LOW    = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_NONE   = 2'd0,
        SEL_LOW    = 2'd1,
        SEL_MEDIUM = 2'd2,
        SEL_HIGH   = 2'd3
    } cost_sel_t;

    localparam logic [BASE_W-1:0] NT_A = 3'd0;
    localparam logic [BASE_W-1:0] NT_C = 3'd1;
    localparam logic [BASE_W-1:0] NT_G = 3'd2;
    localparam logic [BASE_W-1:0] NT_T = 3'd3;

    function automatic logic [BASE_W-1:0] comp_base(input logic [BASE_W-1:0] b,
                                                     input logic rev);
        if (!rev || b > NT_T)
            return b;
        return NT_T - b;
    endfunction

    function automatic cost_sel_t base_cost_sel(input logic ct,
                                                input logic [BASE_W-1:0] rd,
                                                input logic [BASE_W-1:0] rf,
                                                input logic [BASE_W-1:0] nx,
                                                input logic isl);
        logic [BASE_W-1:0] from_b;
        logic [BASE_W-1:0] to_b;
        logic [BASE_W-1:0] partner;
        from_b  = ct ? NT_C : NT_G;
        to_b    = ct ? NT_T : NT_A;
        partner = ct ? NT_G : NT_C;
        if (rd > NT_T || rf > NT_T)
            return SEL_NONE;
        if (rd != from_b && rd != to_b)
            return (rf != rd) ? SEL_HIGH : SEL_NONE;
        if (rd == to_b && rf == from_b) begin
            if (nx == partner)
                return isl ? SEL_MEDIUM : SEL_HIGH;
            return SEL_LOW;
        end
        if (rd == from_b && rf == from_b) begin
            if (nx == partner)
                return isl ? SEL_MEDIUM : SEL_LOW;
            return SEL_HIGH;
        end
        if (rd == from_b && nx == to_b)
            return SEL_HIGH;
        return SEL_NONE;
    endfunction

endpackage

/* rtl/bas_select.sv */
// ---------------------------------------------------------------------------
// Bisulfite alignment scorer - genome selection
// Compare tree picking the smallest total, lowest index on ties.
// ---------------------------------------------------------------------------
module bas_select #(
    parameter int NUM_GENOMES = bas_pkg::NUM_GENOMES_DEF,
    parameter int TOTAL_WIDTH = bas_pkg::TOTAL_WIDTH_DEF
) (
    input  logic [TOTAL_WIDTH-1:0]        totals [NUM_GENOMES],
    output logic [bas_pkg::GENOME_W-1:0]  chosen_genome,
    output logic [bas_pkg::PEN_W-1:0]     best_penalty,
    output logic                          best_saturated
);

    localparam int IW = $clog2(NUM_GENOMES);
    localparam int P  = 2 ** IW;
    localparam int EW = (TOTAL_WIDTH > bas_pkg::PEN_W) ? TOTAL_WIDTH : bas_pkg::PEN_W;

    // heap layout: leaves at P..2P-1, root at 1; unused leaves carry the extra key bit
    logic [TOTAL_WIDTH:0] key_next [2*P];
    logic [IW-1:0]        idx_next [2*P];
    logic [TOTAL_WIDTH-1:0] best_val;
    logic [EW-1:0]          best_ext;

    always_comb begin
        for (int i = 0; i < 2*P; i++) begin
            key_next[i] = '1;
            idx_next[i] = '0;
        end
        for (int i = 0; i < P; i++) begin
            if (i < NUM_GENOMES)
                key_next[P+i] = {1'b0, totals[i]};
            idx_next[P+i] = IW'(i);
        end
        for (int k = P-1; k >= 1; k--) begin
            if (key_next[2*k+1] < key_next[2*k]) begin
                key_next[k] = key_next[2*k+1];
                idx_next[k] = idx_next[2*k+1];
            end else begin
                key_next[k] = key_next[2*k];
                idx_next[k] = idx_next[2*k];
            end
        end
    end

    assign best_val       = key_next[1][TOTAL_WIDTH-1:0];
    assign best_ext       = EW'(best_val);
    assign chosen_genome  = bas_pkg::GENOME_W'(idx_next[1]);
    assign best_penalty   = (best_ext > EW'({bas_pkg::PEN_W{1'b1}})) ?
                            '1 : best_ext[bas_pkg::PEN_W-1:0];
    assign best_saturated = (best_val == {TOTAL_WIDTH{1'b1}});

endmodule

/* rtl/bisulfite_alignment_scorer_core.sv */
// ---------------------------------------------------------------------------
// Bisulfite alignment scorer
// Accumulates per-genome alignment penalties and reports the best genome.
// ---------------------------------------------------------------------------
// Usage:
//   Items arrive on the s_ channel, one alignment event each. s_tlast marks
//   the final item of a read; only that item produces a result on the m_
//   channel (chosen genome, its total, saturation flag).
//   Costs are written through cfg_valid/cfg_index/cfg_data while idle;
//   cfg_ready is always high and indexes past the list are ignored.
//   Pipeline: input register, increment stage (base rules or the 16x12
//   indel multiply), accumulate stage (one saturating add on the addressed
//   total, snapshot and clear on last), compare tree into the output register.
//   Throughput is one item per cycle while not held; a read's result shows
//   on m_tvalid after the input, increment, accumulate and output registers.
//   The whole pipeline advances together; while m_tvalid is high and
//   m_tready low it holds and s_tready drops, so nothing is lost.
//   Reset clears all totals and costs to zero and empties the pipeline.
// ---------------------------------------------------------------------------
module bisulfite_alignment_scorer_core #(
    parameter int NUM_GENOMES = bas_pkg::NUM_GENOMES_DEF,
    parameter int CT_GENOMES  = bas_pkg::CT_GENOMES_DEF,
    parameter int TOTAL_WIDTH = bas_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode[1:0] genome_index[4:2] read_base[7:5] ref_base[10:8]
    // next_ref_base[13:11] reverse_strand[14] in_island[15] run_length[27:16]
    input  logic [bas_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // chosen_genome[2:0] best_penalty[34:3] best_saturated[35]
    output logic [bas_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bas_pkg::COST_REG_W-1:0]   cfg_data
);

    `include "bisulfite_alignment_scorer_core_defines.svh"

    localparam int GW = $clog2(NUM_GENOMES);
    localparam int SW = ((TOTAL_WIDTH > bas_pkg::INC_W) ? TOTAL_WIDTH : bas_pkg::INC_W) + 1;
    localparam logic [TOTAL_WIDTH-1:0] TOT_MAX = '1;

    logic en;

    logic [bas_pkg::COST_REG_W-1:0] high_cost_reg;
    logic [bas_pkg::COST_REG_W-1:0] medium_cost_reg;
    logic [bas_pkg::COST_REG_W-1:0] low_cost_reg;

    // input register
    logic                          v1_reg;
    bas_pkg::mode_t                mode1_reg;
    logic [bas_pkg::GENOME_W-1:0]  g1_reg;
    logic [bas_pkg::BASE_W-1:0]    rd1_reg;
    logic [bas_pkg::BASE_W-1:0]    rf1_reg;
    logic [bas_pkg::BASE_W-1:0]    nx1_reg;
    logic                          rev1_reg;
    logic                          isl1_reg;
    logic [bas_pkg::LEN_W-1:0]     len1_reg;
    logic                          last1_reg;

    // increment stage
    logic                          v2_reg;
    logic [bas_pkg::GENOME_W-1:0]  g2_reg;
    logic                          unmapped2_reg;
    logic                          last2_reg;
    logic [bas_pkg::INC_W-1:0]     inc2_reg;
    logic [bas_pkg::INC_W-1:0]     inc_next;
    bas_pkg::cost_sel_t            sel_next;
    logic                          ct_next;

    // accumulate stage
    logic [TOTAL_WIDTH-1:0] totals_reg [NUM_GENOMES];
    logic [TOTAL_WIDTH-1:0] upd_next   [NUM_GENOMES];
    logic [TOTAL_WIDTH-1:0] snap_reg   [NUM_GENOMES];
    logic                   v3_reg;
    logic [GW-1:0]          g2_idx;
    logic                   g_ok;
    logic [SW-1:0]          sum_next;
    logic [TOTAL_WIDTH-1:0] new_total;
    logic                   totals_zero;

    // output register
    logic                          m_valid_reg;
    logic [bas_pkg::GENOME_W-1:0]  chosen_reg;
    logic [bas_pkg::PEN_W-1:0]     best_pen_reg;
    logic                          best_sat_reg;
    logic [bas_pkg::GENOME_W-1:0]  chosen_next;
    logic [bas_pkg::PEN_W-1:0]     best_pen_next;
    logic                          best_sat_next;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'd0, best_sat_reg, best_pen_reg, chosen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_cost_reg   <= '0;
            medium_cost_reg <= '0;
            low_cost_reg    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                bas_pkg::CFG_HIGH:   high_cost_reg   <= cfg_data;
                bas_pkg::CFG_MEDIUM: medium_cost_reg <= cfg_data;
                bas_pkg::CFG_LOW:    low_cost_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- increment stage logic ----
    always_comb begin
        ct_next  = int'(g1_reg) < CT_GENOMES;
        sel_next = bas_pkg::base_cost_sel(ct_next, rd1_reg,
                                          bas_pkg::comp_base(rf1_reg, rev1_reg),
                                          bas_pkg::comp_base(nx1_reg, rev1_reg),
                                          isl1_reg);
        inc_next = '0;
        case (mode1_reg)
            bas_pkg::MODE_MATCH: begin
                case (sel_next)
                    bas_pkg::SEL_LOW:    inc_next = bas_pkg::INC_W'(low_cost_reg);
                    bas_pkg::SEL_MEDIUM: inc_next = bas_pkg::INC_W'(medium_cost_reg);
                    bas_pkg::SEL_HIGH:   inc_next = bas_pkg::INC_W'(high_cost_reg);
                    default:             inc_next = '0;
                endcase
            end
            bas_pkg::MODE_DEL, bas_pkg::MODE_INS:
                inc_next = bas_pkg::INC_W'(high_cost_reg) * bas_pkg::INC_W'(len1_reg);
            default: inc_next = '0;
        endcase
    end

    // ---- accumulate stage logic: one saturating add on the addressed total ----
    always_comb begin
        g2_idx    = GW'(g2_reg);
        g_ok      = int'(g2_reg) < NUM_GENOMES;
        sum_next  = SW'(totals_reg[g2_idx]) + SW'(inc2_reg);
        if (unmapped2_reg || sum_next > SW'(TOT_MAX))
            new_total = TOT_MAX;
        else
            new_total = sum_next[TOTAL_WIDTH-1:0];
        for (int i = 0; i < NUM_GENOMES; i++)
            upd_next[i] = (g_ok && g2_idx == GW'(i)) ? new_total : totals_reg[i];
    end

    always_comb begin
        totals_zero = 1'b1;
        for (int i = 0; i < NUM_GENOMES; i++)
            if (totals_reg[i] != '0)
                totals_zero = 1'b0;
    end

    bas_select #(
        .NUM_GENOMES (NUM_GENOMES),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_select (
        .totals         (snap_reg),
        .chosen_genome  (chosen_next),
        .best_penalty   (best_pen_next),
        .best_saturated (best_sat_next)
    );

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_GENOMES; i++)
                totals_reg[i] <= '0;
        end else if (en) begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg && last2_reg;
            m_valid_reg <= v3_reg;
            if (v2_reg) begin
                for (int i = 0; i < NUM_GENOMES; i++)
                    totals_reg[i] <= last2_reg ? '0 : upd_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            if (s_tvalid) begin
                mode1_reg <= bas_pkg::mode_t'(s_tdata[1:0]);
                g1_reg    <= s_tdata[4:2];
                rd1_reg   <= s_tdata[7:5];
                rf1_reg   <= s_tdata[10:8];
                nx1_reg   <= s_tdata[13:11];
                rev1_reg  <= s_tdata[14];
                isl1_reg  <= s_tdata[15];
                len1_reg  <= s_tdata[27:16];
                last1_reg <= s_tlast;
            end
            if (v1_reg) begin
                g2_reg        <= g1_reg;
                unmapped2_reg <= (mode1_reg == bas_pkg::MODE_UNMAPPED);
                last2_reg     <= last1_reg;
                inc2_reg      <= inc_next;
            end
            if (v2_reg && last2_reg)
                snap_reg <= upd_next;
            if (v3_reg) begin
                chosen_reg   <= chosen_next;
                best_pen_reg <= best_pen_next;
                best_sat_reg <= best_sat_next;
            end
        end
    end

    `BAS_ASSERT(a_last_clears, (en && v2_reg && last2_reg) |=> totals_zero, "totals not cleared after last item")
    `BAS_ASSERT(a_result_source, $rose(m_valid_reg) |-> $past(v3_reg), "result without a selected read")
    `BAS_ASSERT(a_unmapped_sat, (en && v2_reg && unmapped2_reg && !last2_reg && g_ok) |=> (totals_reg[$past(g2_idx)] == TOT_MAX), "unmapped mark did not saturate total")

endmodule

/* tb/bisulfite_alignment_scorer_core_tb.sv */
// ----------------------------------------------------------------------------
// Bisulfite alignment scorer - testbench
// Streams alignment events into the scorer and checks each selected genome,
// its total and its saturation flag against a cycle-free scoring model kept
// here. Directed events cover every scoring rule. Random reads run before them at
// reset costs and after them under several cost settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module bisulfite_alignment_scorer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bas_pkg::*;

    localparam int GENOMES    = NUM_GENOMES_DEF;
    localparam int CT_LIMIT   = CT_GENOMES_DEF;
    localparam int STALL_MAX  = 17;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        mode_t             mode;
        logic [GENOME_W-1:0] genome;
        logic [BASE_W-1:0] rd;
        logic [BASE_W-1:0] rf;
        logic [BASE_W-1:0] nx;
        logic              rev;
        logic              isl;
        logic [LEN_W-1:0]  run_len;
        logic              last;
    } align_event_t;

    typedef struct {
        logic [GENOME_W-1:0] genome;
        logic [PEN_W-1:0]    penalty;
        logic                saturated;
    } genome_pick_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COST_REG_W-1:0] cfg_data = '0;

    // scoring state mirrored from the block
    logic [COST_REG_W-1:0] cost_high = '0;
    logic [COST_REG_W-1:0] cost_medium = '0;
    logic [COST_REG_W-1:0] cost_low = '0;
    logic [PEN_W-1:0] genome_totals [GENOMES];

    align_event_t pending_events [$];
    genome_pick_t due_picks [$];
    align_event_t cur_event;

    logic s_fire = 1'b0;
    logic m_fire = 1'b0;
    bit steady = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_hold;
    int idle_cycles = 0;
    int fail_count = 0;

    bisulfite_alignment_scorer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- model

    // reverse strand: A<->T, C<->G is the bitwise inverse of the 2-bit code
    function automatic logic [BASE_W-1:0] strand_base(input logic [BASE_W-1:0] b,
                                                      input logic rev);
        if (rev && !b[2])
            return {1'b0, ~b[1:0]};
        return b;
    endfunction

    function automatic logic [PEN_W-1:0] match_penalty(input logic ct,
                                                       input logic [BASE_W-1:0] rd,
                                                       input logic [BASE_W-1:0] rf,
                                                       input logic [BASE_W-1:0] nx,
                                                       input logic isl);
        logic [BASE_W-1:0] src;
        logic [BASE_W-1:0] dst;
        logic [BASE_W-1:0] pair;
        logic [COST_REG_W-1:0] c;
        src  = ct ? NT_C : NT_G;
        dst  = ct ? NT_T : NT_A;
        pair = ct ? NT_G : NT_C;
        c    = '0;
        if (rd[2] || rf[2])
            c = '0;
        else if (rd != src && rd != dst)
            c = (rf != rd) ? cost_high : '0;
        else if (rd == dst && rf == src)
            c = (nx == pair) ? (isl ? cost_medium : cost_high) : cost_low;
        else if (rd == src && rf == src)
            c = (nx == pair) ? (isl ? cost_medium : cost_low) : cost_high;
        else if (rd == src && nx == dst)
            c = cost_high;
        return PEN_W'(c);
    endfunction

    task automatic score_event(input align_event_t ev);
        logic [PEN_W:0] sum;
        logic [PEN_W-1:0] inc;
        genome_pick_t pick;
        if (ev.genome < GENOMES) begin
            if (ev.mode == MODE_UNMAPPED) begin
                genome_totals[ev.genome] = '1;
            end else begin
                if (ev.mode == MODE_MATCH)
                    inc = match_penalty(ev.genome < CT_LIMIT, ev.rd,
                                        strand_base(ev.rf, ev.rev),
                                        strand_base(ev.nx, ev.rev), ev.isl);
                else
                    inc = PEN_W'(cost_high) * PEN_W'(ev.run_len);
                sum = {1'b0, genome_totals[ev.genome]} + {1'b0, inc};
                genome_totals[ev.genome] = sum[PEN_W] ? '1 : sum[PEN_W-1:0];
            end
        end
        if (ev.last) begin
            pick.genome  = '0;
            pick.penalty = genome_totals[0];
            for (int i = 1; i < GENOMES; i++) begin
                if (genome_totals[i] < pick.penalty) begin
                    pick.genome  = GENOME_W'(i);
                    pick.penalty = genome_totals[i];
                end
            end
            pick.saturated = (pick.penalty == '1);
            due_picks.push_back(pick);
            foreach (genome_totals[i])
                genome_totals[i] = '0;
        end
    endtask

    // ------------------------------------------------------------- stimulus

    function automatic logic [IN_DATA_W-1:0] pack_event(input align_event_t ev);
        return IN_DATA_W'({ev.run_len, ev.isl, ev.rev, ev.nx, ev.rf, ev.rd,
                           ev.genome, ev.mode});
    endfunction

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, STALL_MAX);
    endfunction

    function automatic void push_event(input mode_t m, input int g, input int rd,
                                       input int rf, input int nx, input bit rev,
                                       input bit isl, input int len, input bit last);
        align_event_t ev;
        ev.mode    = m;
        ev.genome  = GENOME_W'(g);
        ev.rd      = BASE_W'(rd);
        ev.rf      = BASE_W'(rf);
        ev.nx      = BASE_W'(nx);
        ev.rev     = rev;
        ev.isl     = isl;
        ev.run_len = LEN_W'(len);
        ev.last    = last;
        pending_events.push_back(ev);
    endfunction

    function automatic int pick_base();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    endfunction

    // one read: random events ending on a last item; returns the item count
    function automatic int queue_read();
        int n;
        int r;
        int len;
        bit heavy;
        mode_t m;
        heavy = ($urandom_range(0, 9) == 0);
        n = heavy ? 40 : $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (heavy)
                m = r[0] ? MODE_DEL : MODE_INS;
            else if (r < 72)
                m = MODE_MATCH;
            else if (r < 84)
                m = MODE_DEL;
            else if (r < 96)
                m = MODE_INS;
            else
                m = MODE_UNMAPPED;
            case ($urandom_range(0, 7))
                0:       len = $urandom_range(0, 4095);
                1:       len = 4095;
                default: len = $urandom_range(0, 15);
            endcase
            if (heavy)
                len = 4095;
            // odd last flags mid-read as noise
            push_event(m, ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, GENOMES - 1),
                       pick_base(), pick_base(), pick_base(), $urandom_range(0, 1),
                       $urandom_range(0, 1), len,
                       (i == n - 1) || ($urandom_range(0, 39) == 0));
        end
        return n;
    endfunction

    task automatic write_cost(input cfg_idx_t idx, input logic [COST_REG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HIGH:   cost_high = val;
            CFG_MEDIUM: cost_medium = val;
            CFG_LOW:    cost_low = val;
            default: ;
        endcase
    endtask

    task automatic set_costs(input int hi, input int med, input int lo);
        write_cost(CFG_HIGH, COST_REG_W'(hi));
        write_cost(CFG_MEDIUM, COST_REG_W'(med));
        write_cost(CFG_LOW, COST_REG_W'(lo));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // let every item drain and the pipeline settle
    task automatic wait_quiet();
        do @(posedge aclk);
        while (s_tvalid || pending_events.size() != 0 || due_picks.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        int n;
        foreach (genome_totals[i])
            genome_totals[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // costs still at reset value
        n = 0;
        while (n < 40)
            n += queue_read();
        wait_quiet();

        set_costs(1000, 100, 10);
        steady = 1'b1;
        // C-to-T genomes
        push_event(MODE_MATCH, 0, NT_T, NT_C, NT_G, 0, 1, 0, 0);
        push_event(MODE_MATCH, 0, NT_T, NT_C, NT_G, 0, 0, 0, 0);
        push_event(MODE_MATCH, 0, NT_T, NT_C, NT_A, 0, 0, 0, 0);
        push_event(MODE_MATCH, 1, NT_C, NT_C, NT_G, 0, 1, 0, 0);
        push_event(MODE_MATCH, 1, NT_C, NT_C, NT_G, 0, 0, 0, 0);
        push_event(MODE_MATCH, 1, NT_C, NT_C, NT_T, 0, 0, 0, 0);
        push_event(MODE_MATCH, 2, NT_C, NT_A, NT_T, 0, 0, 0, 0);
        push_event(MODE_MATCH, 2, NT_A, NT_G, NT_A, 0, 0, 0, 0);
        push_event(MODE_MATCH, 2, NT_G, NT_G, 7, 1, 1, 4095, 0);
        // unknown read or reference base scores nothing
        push_event(MODE_MATCH, 3, 4, NT_A, NT_A, 0, 0, 0, 0);
        push_event(MODE_MATCH, 3, NT_A, 7, NT_A, 0, 0, 0, 0);
        // G-to-A genomes
        push_event(MODE_MATCH, 4, NT_A, NT_G, NT_C, 0, 1, 0, 0);
        push_event(MODE_MATCH, 5, NT_G, NT_G, NT_C, 0, 0, 0, 0);
        push_event(MODE_MATCH, 6, NT_G, NT_T, NT_A, 0, 0, 0, 0);
        // reverse strand complements both reference bases
        push_event(MODE_MATCH, 4, NT_A, NT_C, NT_G, 1, 0, 0, 0);
        push_event(MODE_DEL, 6, 0, 0, 0, 0, 0, 4095, 0);
        push_event(MODE_INS, 5, 0, 0, 0, 0, 0, 0, 0);
        push_event(MODE_UNMAPPED, 3, 0, 0, 0, 0, 0, 0, 0);
        // genome past the last one touches no total
        push_event(MODE_UNMAPPED, 7, 0, 0, 0, 0, 0, 0, 0);
        push_event(MODE_MATCH, 7, NT_A, NT_C, NT_A, 0, 0, 0, 1);
        // all totals equal: lowest index wins
        push_event(MODE_MATCH, 7, NT_A, NT_C, NT_A, 0, 0, 0, 1);
        push_event(MODE_INS, 0, 0, 0, 0, 0, 0, 12, 1);
        wait_quiet();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_costs(65535, 65535, 65535);
                1: set_costs(0, 0, 0);
                2: set_costs(65535, 0, 1);
                3: set_costs(1, 65535, 65535);
                4: set_costs($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
                default: set_costs($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535));
            endcase
            steady = (phase % 3 == 1);
            n = 0;
            while (n < PHASE_ITEMS)
                n += queue_read();
            wait_quiet();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // --------------------------------------------------------- bus drivers

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // item still waiting for tready
        end else if (send_wait != 0) begin
            send_wait <= send_wait - 1;
            s_tvalid  <= 1'b0;
        end else if (pending_events.size() != 0) begin
            cur_event = pending_events.pop_front();
            s_tdata   <= pack_event(cur_event);
            s_tlast   <= cur_event.last;
            s_tvalid  <= 1'b1;
            send_wait <= draw_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // stall count runs down only while a result is offered
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            recv_hold = m_fire ? draw_gap() : recv_wait;
            if (recv_hold != 0) begin
                m_tready  <= 1'b0;
                recv_wait <= m_tvalid ? recv_hold - 1 : recv_hold;
            end else begin
                m_tready  <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    // ------------------------------------------------------ monitor / check

    always @(posedge aclk) begin
        genome_pick_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_picks.size() == 0) begin
                $error("result with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = due_picks.pop_front();
                if (m_tdata[2:0] !== want.genome) begin
                    $error("chosen_genome: expected %0d, got %0d", want.genome, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[34:3] !== want.penalty) begin
                    $error("best_penalty: expected %0d, got %0d", want.penalty, m_tdata[34:3]);
                    fail_count++;
                end
                if (m_tdata[35] !== want.saturated) begin
                    $error("best_saturated: expected %0d, got %0d", want.saturated, m_tdata[35]);
                    fail_count++;
                end
            end
        end
        // expectation goes in after the check so a stray result cannot claim it
        if (aresetn && s_tvalid && s_tready)
            score_event(cur_event);

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
